// File: design/fsgs_pkg.sv
// fsgs_pkg: shared constants, beat types and control types of the falling sand grid
// used by fsgs_ctrl, fsgs_dp and falling_sand_grid_step; depends on nothing
package fsgs_pkg;

    // grid geometry
    localparam int GRID_COLS  = 64;
    localparam int GRID_ROWS  = 64;
    localparam int WORD_W     = 64;
    localparam int COL_W      = $clog2(GRID_COLS);
    localparam int ROW_W      = 6;
    localparam int CHUNK_ROWS = 8;
    localparam int CHUNK_W    = ROW_W - $clog2(CHUNK_ROWS);
    localparam int NCHUNK     = (GRID_ROWS + CHUNK_ROWS - 1) / CHUNK_ROWS;

    // side-choice lfsr
    localparam int                SEED_W     = 32;
    localparam logic [SEED_W-1:0] LFSR_TAPS  = 32'h8020_0003;
    localparam logic [SEED_W-1:0] LFSR_RESET = 32'd1;

    // rows that exist in a column word
    localparam logic [WORD_W-1:0] ROW_MASK = (GRID_ROWS >= WORD_W) ? '1 :
        WORD_W'((65'd1 << GRID_ROWS) - 65'd1);

    // request kinds
    localparam logic [1:0] REQ_PLACE   = 2'd0;
    localparam logic [1:0] REQ_ADVANCE = 2'd1;
    localparam logic [1:0] REQ_READ    = 2'd2;

    typedef struct packed {
        logic [1:0] req_type;
        logic [5:0] col_index;
        logic [5:0] row_index;
    } t_in_beat;

    typedef struct packed {
        logic [WORD_W-1:0] column_bits;
        logic [1:0]        done_kind;
    } t_out_beat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PLACE_RD,
        S_PLACE_WR,
        S_READ_RD,
        S_GEN_RD0,
        S_GEN_RD1,
        S_GEN_RD2,
        S_SCAN,
        S_FLUSH,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LATCH,
        OP_REQ_READ,
        OP_PLACE_WRITE,
        OP_GEN_READ0,
        OP_GEN_READ1,
        OP_GEN_READ2,
        OP_SCAN,
        OP_FLUSH
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic scan_last;
    } t_dp_stat;

endpackage

// File: design/fsgs_ctrl.sv
// fsgs_ctrl: request sequencer of the falling sand grid
// depends on fsgs_pkg; drives fsgs_dp through command and status structs
module fsgs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [1:0]         i_req_type,
    input  fsgs_pkg::t_dp_stat i_stat,
    input  logic               i_out_busy,
    output logic               o_in_ready,
    output fsgs_pkg::t_ctrl_cmd o_cmd
);

    fsgs_pkg::t_state r_state;
    fsgs_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fsgs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            fsgs_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    case (i_req_type)
                        fsgs_pkg::REQ_PLACE:   n_state = fsgs_pkg::S_PLACE_RD;
                        fsgs_pkg::REQ_ADVANCE: n_state = fsgs_pkg::S_GEN_RD0;
                        fsgs_pkg::REQ_READ:    n_state = fsgs_pkg::S_READ_RD;
                        default:               n_state = fsgs_pkg::S_IDLE;
                    endcase
                end
            end
            fsgs_pkg::S_PLACE_RD: n_state = fsgs_pkg::S_PLACE_WR;
            fsgs_pkg::S_PLACE_WR: n_state = fsgs_pkg::S_DONE;
            fsgs_pkg::S_READ_RD:  n_state = fsgs_pkg::S_DONE;
            fsgs_pkg::S_GEN_RD0:  n_state = fsgs_pkg::S_GEN_RD1;
            fsgs_pkg::S_GEN_RD1:  n_state = fsgs_pkg::S_GEN_RD2;
            fsgs_pkg::S_GEN_RD2:  n_state = fsgs_pkg::S_SCAN;
            fsgs_pkg::S_SCAN: begin
                if (i_stat.scan_last) begin
                    n_state = fsgs_pkg::S_FLUSH;
                end
            end
            fsgs_pkg::S_FLUSH: n_state = fsgs_pkg::S_DONE;
            fsgs_pkg::S_DONE: begin
                if (!i_out_busy) begin
                    n_state = fsgs_pkg::S_IDLE;
                end
            end
            default: n_state = fsgs_pkg::S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd.op       = fsgs_pkg::OP_IDLE;
        o_cmd.load_out = 1'b0;
        case (r_state)
            fsgs_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = fsgs_pkg::OP_LATCH;
                end
            end
            fsgs_pkg::S_PLACE_RD: o_cmd.op = fsgs_pkg::OP_REQ_READ;
            fsgs_pkg::S_PLACE_WR: o_cmd.op = fsgs_pkg::OP_PLACE_WRITE;
            fsgs_pkg::S_READ_RD:  o_cmd.op = fsgs_pkg::OP_REQ_READ;
            fsgs_pkg::S_GEN_RD0:  o_cmd.op = fsgs_pkg::OP_GEN_READ0;
            fsgs_pkg::S_GEN_RD1:  o_cmd.op = fsgs_pkg::OP_GEN_READ1;
            fsgs_pkg::S_GEN_RD2:  o_cmd.op = fsgs_pkg::OP_GEN_READ2;
            fsgs_pkg::S_SCAN:     o_cmd.op = fsgs_pkg::OP_SCAN;
            fsgs_pkg::S_FLUSH:    o_cmd.op = fsgs_pkg::OP_FLUSH;
            fsgs_pkg::S_DONE:     o_cmd.load_out = !i_out_busy;
            default:              o_cmd.op = fsgs_pkg::OP_IDLE;
        endcase
    end

endmodule

// File: design/fsgs_dp.sv
// fsgs_dp: grid memory, three-column window, next-generation accumulators and lfsr
// depends on fsgs_pkg; sequenced by fsgs_ctrl
module fsgs_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  fsgs_pkg::t_in_beat        i_in_beat,
    input  logic                      i_cfg_wr_en,
    input  logic [fsgs_pkg::SEED_W-1:0] i_cfg_wr_data,
    input  fsgs_pkg::t_ctrl_cmd       i_cmd,
    output fsgs_pkg::t_dp_stat        o_stat,
    output fsgs_pkg::t_out_beat       o_result
);

    // grid memory, one word per column
    logic [fsgs_pkg::WORD_W-1:0] r_mem [fsgs_pkg::GRID_COLS];
    logic [fsgs_pkg::GRID_COLS-1:0] r_valid;
    logic [fsgs_pkg::WORD_W-1:0] r_rd_q;
    logic                        r_rd_v;

    logic                        mem_we;
    logic [fsgs_pkg::COL_W-1:0]  mem_waddr;
    logic [fsgs_pkg::WORD_W-1:0] mem_wdata;
    logic                        mem_re;
    logic [fsgs_pkg::COL_W-1:0]  mem_raddr;
    logic [fsgs_pkg::WORD_W-1:0] rd_word;

    // request and scan position
    fsgs_pkg::t_in_beat            r_req;
    logic [fsgs_pkg::COL_W-1:0]    r_col;
    logic [fsgs_pkg::CHUNK_W-1:0]  r_chunk;
    logic [fsgs_pkg::SEED_W-1:0]   r_lfsr;
    logic [fsgs_pkg::SEED_W-1:0]   n_lfsr;

    // old-grid window and new-grid accumulators
    logic [fsgs_pkg::WORD_W-1:0] r_left;
    logic [fsgs_pkg::WORD_W-1:0] r_mid;
    logic [fsgs_pkg::WORD_W-1:0] r_right;
    logic [fsgs_pkg::WORD_W-1:0] r_acc_left;
    logic [fsgs_pkg::WORD_W-1:0] r_acc_mid;
    logic [fsgs_pkg::WORD_W-1:0] r_acc_right;
    logic [fsgs_pkg::WORD_W-1:0] n_acc_left;
    logic [fsgs_pkg::WORD_W-1:0] n_acc_mid;
    logic [fsgs_pkg::WORD_W-1:0] n_acc_right;

    logic chunk_last;
    logic col_last;
    logic col_ok;
    logic row_ok;
    logic right_in_grid;
    logic prefetch_ok;

    assign rd_word       = r_rd_v ? r_rd_q : '0;
    assign chunk_last    = (r_chunk == fsgs_pkg::CHUNK_W'(fsgs_pkg::NCHUNK - 1));
    assign col_last      = (r_col == fsgs_pkg::COL_W'(fsgs_pkg::GRID_COLS - 1));
    assign col_ok        = (32'(r_req.col_index) < 32'(fsgs_pkg::GRID_COLS));
    assign row_ok        = (32'(r_req.row_index) < 32'(fsgs_pkg::GRID_ROWS));
    assign right_in_grid = ((32'(r_col) + 32'd2) < 32'(fsgs_pkg::GRID_COLS));
    assign prefetch_ok   = ((32'(r_col) + 32'd3) < 32'(fsgs_pkg::GRID_COLS));

    assign o_stat.scan_last = chunk_last && col_last;

    // result of the finished request
    assign o_result.done_kind   = r_req.req_type;
    assign o_result.column_bits = (r_req.req_type == fsgs_pkg::REQ_READ && col_ok) ?
                                  (rd_word & fsgs_pkg::ROW_MASK) : '0;

    // one chunk of rows: move grains of the middle column, step lfsr per blocked grain
    always_comb begin
        logic [fsgs_pkg::WORD_W-1:0] below_l;
        logic [fsgs_pkg::WORD_W-1:0] below_m;
        logic [fsgs_pkg::WORD_W-1:0] below_r;
        logic [fsgs_pkg::ROW_W-1:0]  row;
        logic [fsgs_pkg::ROW_W-1:0]  row_dn;
        logic                        left_free;
        logic                        right_free;
        n_lfsr      = r_lfsr;
        n_acc_left  = r_acc_left;
        n_acc_mid   = r_acc_mid;
        n_acc_right = r_acc_right;
        below_l     = r_left >> 1;
        below_m     = r_mid >> 1;
        below_r     = r_right >> 1;
        for (int k = 0; k < fsgs_pkg::CHUNK_ROWS; k++) begin
            row        = {r_chunk, 3'(k)};
            row_dn     = row + fsgs_pkg::ROW_W'(1);
            left_free  = !below_l[row];
            right_free = !below_r[row];
            if (r_mid[row] && (32'(row) < 32'(fsgs_pkg::GRID_ROWS))) begin
                if (32'(row) == 32'(fsgs_pkg::GRID_ROWS - 1)) begin
                    n_acc_mid[row] = 1'b1;
                end else if (!below_m[row]) begin
                    n_acc_mid[row_dn] = 1'b1;
                end else begin
                    n_lfsr = {1'b0, n_lfsr[fsgs_pkg::SEED_W-1:1]} ^
                             (n_lfsr[0] ? fsgs_pkg::LFSR_TAPS : '0);
                    if (n_lfsr[0]) begin
                        // right side first
                        if (right_free) begin
                            n_acc_right[row_dn] = 1'b1;
                        end else if (left_free) begin
                            n_acc_left[row_dn] = 1'b1;
                        end else begin
                            n_acc_mid[row] = 1'b1;
                        end
                    end else begin
                        // left side first
                        if (left_free) begin
                            n_acc_left[row_dn] = 1'b1;
                        end else if (right_free) begin
                            n_acc_right[row_dn] = 1'b1;
                        end else begin
                            n_acc_mid[row] = 1'b1;
                        end
                    end
                end
            end
        end
    end

    // memory port selection
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = fsgs_pkg::COL_W'(r_req.col_index);
        mem_wdata = rd_word | (fsgs_pkg::WORD_W'(1) << r_req.row_index);
        mem_re    = 1'b0;
        mem_raddr = fsgs_pkg::COL_W'(r_req.col_index);
        case (i_cmd.op)
            fsgs_pkg::OP_REQ_READ: begin
                mem_re = 1'b1;
            end
            fsgs_pkg::OP_PLACE_WRITE: begin
                mem_we = col_ok && row_ok;
            end
            fsgs_pkg::OP_GEN_READ0: begin
                mem_re    = 1'b1;
                mem_raddr = '0;
            end
            fsgs_pkg::OP_GEN_READ1: begin
                mem_re    = 1'b1;
                mem_raddr = fsgs_pkg::COL_W'(1);
            end
            fsgs_pkg::OP_GEN_READ2: begin
                mem_re    = (32'd2 < 32'(fsgs_pkg::GRID_COLS));
                mem_raddr = fsgs_pkg::COL_W'(2);
            end
            fsgs_pkg::OP_SCAN: begin
                // at column end: retire the finished column to the left, fetch ahead
                mem_we    = chunk_last && (r_col != '0);
                mem_waddr = r_col - fsgs_pkg::COL_W'(1);
                mem_wdata = n_acc_left;
                mem_re    = chunk_last && prefetch_ok;
                mem_raddr = fsgs_pkg::COL_W'(32'(r_col) + 32'd3);
            end
            fsgs_pkg::OP_FLUSH: begin
                mem_we    = 1'b1;
                mem_waddr = fsgs_pkg::COL_W'(fsgs_pkg::GRID_COLS - 1);
                mem_wdata = r_acc_left;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // grid memory with registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_q <= r_mem[mem_raddr];
        end
    end

    // per-column written flags, cleared grid reads as empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_v  <= 1'b0;
        end else begin
            if (mem_we) begin
                r_valid[mem_waddr] <= 1'b1;
            end
            if (mem_re) begin
                r_rd_v <= r_valid[mem_raddr];
            end
        end
    end

    // side-choice lfsr, seed write loads it at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr <= fsgs_pkg::LFSR_RESET;
        end else if (i_cfg_wr_en) begin
            r_lfsr <= (i_cfg_wr_data == '0) ? fsgs_pkg::LFSR_RESET : i_cfg_wr_data;
        end else if (i_cmd.op == fsgs_pkg::OP_SCAN) begin
            r_lfsr <= n_lfsr;
        end
    end

    // request latch, scan window and accumulators
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            fsgs_pkg::OP_LATCH: begin
                r_req <= i_in_beat;
            end
            fsgs_pkg::OP_GEN_READ0: begin
                r_col       <= '0;
                r_chunk     <= '0;
                r_left      <= '1;
                r_acc_left  <= '0;
                r_acc_mid   <= '0;
                r_acc_right <= '0;
            end
            fsgs_pkg::OP_GEN_READ1: begin
                r_mid <= rd_word;
            end
            fsgs_pkg::OP_GEN_READ2: begin
                r_right <= rd_word;
            end
            fsgs_pkg::OP_SCAN: begin
                if (chunk_last) begin
                    r_chunk     <= '0;
                    r_col       <= r_col + fsgs_pkg::COL_W'(1);
                    r_left      <= r_mid;
                    r_mid       <= r_right;
                    r_right     <= right_in_grid ? rd_word : '1;
                    r_acc_left  <= n_acc_mid;
                    r_acc_mid   <= n_acc_right;
                    r_acc_right <= '0;
                end else begin
                    r_chunk     <= r_chunk + fsgs_pkg::CHUNK_W'(1);
                    r_acc_left  <= n_acc_left;
                    r_acc_mid   <= n_acc_mid;
                    r_acc_right <= n_acc_right;
                end
            end
            default: begin
                r_chunk <= r_chunk;
            end
        endcase
    end

endmodule

// File: design/falling_sand_grid_step.sv
// falling_sand_grid_step: one place, advance or read request per input beat, one result beat each.
// a place reads the column word and writes it back with the grain set, a read fetches the word,
// and an advance loads the first columns, scans 8 rows per cycle through a chain of lfsr steps
// and flushes the last column. one request at a time; the next is taken the cycle after
// its result is registered, even while that result waits. synchronous active-low reset
// empties the grid at once through per-column flags and loads the lfsr with 1.
module falling_sand_grid_step (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  fsgs_pkg::t_in_beat           i_in_beat,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output fsgs_pkg::t_out_beat          o_out_beat,
    input  logic                         i_cfg_wr_en,
    input  logic [fsgs_pkg::SEED_W-1:0]  i_cfg_wr_data
);

    fsgs_pkg::t_ctrl_cmd cmd;
    fsgs_pkg::t_dp_stat  stat;
    fsgs_pkg::t_out_beat result;
    fsgs_pkg::t_out_beat r_out_beat;
    logic                r_out_valid;
    logic                out_busy;

    assign out_busy    = r_out_valid && !i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    // sequencer
    fsgs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_in_beat.req_type),
        .i_stat     (stat),
        .i_out_busy (out_busy),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // grid datapath
    fsgs_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_beat     (i_in_beat),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_result      (result)
    );

    // output register, holds a result beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.load_out) begin
            r_out_beat <= result;
        end
    end

endmodule

// File: tb/sv/tb_top.sv
// tb_top: self-checking bench for falling_sand_grid_step, with its own grid and lfsr predictor
// depends on fsgs_pkg and the falling_sand_grid_step rtl only
module tb_top;
    import fsgs_pkg::*;

    localparam logic [1:0] REQ_BOGUS   = 2'd3;
    localparam int         SETTLE_CYC  = GRID_COLS * NCHUNK + 16;
    localparam int         QUIET_LIMIT = 8000;
    localparam int         HOLD_CYC    = 400;
    localparam int         HOLD_AFTER  = 250;
    localparam int         MAX_PRINTS  = 30;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              in_valid    = 1'b0;
    logic              in_ready;
    t_in_beat          in_beat     = '0;
    logic              out_valid;
    logic              out_ready   = 1'b0;
    t_out_beat         out_beat;
    logic              cfg_wr_en   = 1'b0;
    logic [SEED_W-1:0] cfg_wr_data = '0;

    // predictor state: one word per column, bit r is row r
    logic [WORD_W-1:0] pile [GRID_COLS];
    logic [SEED_W-1:0] coin_lfsr;

    t_in_beat  req_q[$];
    t_out_beat want_done[$];

    int idle_pct   = 16;
    int n_err      = 0;
    int n_results  = 0;
    int n_place    = 0;
    int n_adv      = 0;
    int n_read     = 0;
    int n_drop     = 0;
    int n_seeds    = 0;
    int quiet_cyc  = 0;
    int hold_cnt   = 0;
    bit hold_done  = 1'b0;

    falling_sand_grid_step uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_in_beat     (in_beat),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_out_beat    (out_beat),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    // clock
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // one lfsr step, returns the side bit (1 is right)
    function automatic logic coin_flip();
        logic [SEED_W-1:0] v;
        v = coin_lfsr >> 1;
        if (coin_lfsr[0]) begin
            v = v ^ LFSR_TAPS;
        end
        coin_lfsr = v;
        return v[0];
    endfunction

    function automatic bit cell_free(int c, int r);
        return (c >= 0) && (c < GRID_COLS) && !pile[c][r];
    endfunction

    // one generation, every grain judged against the old grid
    function automatic void grid_generation();
        logic [WORD_W-1:0] nxt [GRID_COLS];
        int                d;
        for (int c = 0; c < GRID_COLS; c++) begin
            nxt[c] = '0;
        end
        for (int c = 0; c < GRID_COLS; c++) begin
            for (int r = 0; r < GRID_ROWS; r++) begin
                if (!pile[c][r]) continue;
                if (r == GRID_ROWS - 1) begin
                    nxt[c][r] = 1'b1;
                end else if (!pile[c][r+1]) begin
                    nxt[c][r+1] = 1'b1;
                end else begin
                    d = coin_flip() ? 1 : -1;
                    if (cell_free(c + d, r + 1)) begin
                        nxt[c+d][r+1] = 1'b1;
                    end else if (cell_free(c - d, r + 1)) begin
                        nxt[c-d][r+1] = 1'b1;
                    end else begin
                        nxt[c][r] = 1'b1;
                    end
                end
            end
        end
        pile = nxt;
    endfunction

    // update the grid for one accepted request and return its result beat
    function automatic t_out_beat apply_request(t_in_beat b);
        t_out_beat res;
        res.column_bits = '0;
        res.done_kind   = b.req_type;
        case (b.req_type)
            REQ_PLACE: begin
                if (b.col_index < GRID_COLS && b.row_index < GRID_ROWS) begin
                    pile[b.col_index][b.row_index] = 1'b1;
                end
            end
            REQ_ADVANCE: begin
                grid_generation();
            end
            REQ_READ: begin
                if (b.col_index < GRID_COLS) begin
                    res.column_bits = pile[b.col_index] & ROW_MASK;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report(string field, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
        if (n_err < MAX_PRINTS) begin
            $display("mismatch at result %0d: %s got %h expected %h", n_results, field, got, want);
        end
        n_err++;
    endtask

    function automatic t_in_beat mk(logic [1:0] kind, int c, int r);
        t_in_beat b;
        b.req_type  = kind;
        b.col_index = c[5:0];
        b.row_index = r[5:0];
        return b;
    endfunction

    function automatic int clamp_col(int c);
        return (c < 0) ? 0 : (c > GRID_COLS - 1) ? GRID_COLS - 1 : c;
    endfunction

    // input driver: predicts on each accepted beat, then offers the next one
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                if (in_beat.req_type != REQ_BOGUS) begin
                    want_done.push_back(apply_request(in_beat));
                end
                case (in_beat.req_type)
                    REQ_PLACE:   n_place++;
                    REQ_ADVANCE: n_adv++;
                    REQ_READ:    n_read++;
                    default:     n_drop++;
                endcase
            end
            if (!in_valid || in_ready) begin
                if (req_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    in_beat  <= req_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output ready: random idling plus one long hold while the sender keeps offering
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_cnt != 0) begin
            out_ready <= 1'b0;
            hold_cnt  <= hold_cnt - 1;
        end else if (!hold_done && n_results >= HOLD_AFTER) begin
            out_ready <= 1'b0;
            hold_cnt  <= HOLD_CYC;
            hold_done <= 1'b1;
        end else begin
            out_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // output monitor: compare each result beat with the oldest prediction
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (want_done.size() == 0) begin
                report("unexpected beat", out_beat.column_bits, '0);
            end else begin
                t_out_beat want;
                want = want_done.pop_front();
                if (out_beat.done_kind !== want.done_kind) begin
                    report("done_kind", out_beat.done_kind, want.done_kind);
                end
                if (out_beat.column_bits !== want.column_bits) begin
                    report("column_bits", out_beat.column_bits, want.column_bits);
                end
            end
            n_results <= n_results + 1;
        end
    end

    // watchdog on cycles with no accepted beat on either side
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cyc <= 0;
        end else if (quiet_cyc >= QUIET_LIMIT) begin
            $display("FAIL falling_sand_grid_step");
            $finish;
        end else begin
            quiet_cyc <= quiet_cyc + 1;
        end
    end

    // wait until every queued beat is sent and answered, then let the block settle
    task automatic wait_quiet();
        do @(negedge clk); while (req_q.size() != 0 || in_valid || want_done.size() != 0);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // seed write while idle; a zero seed falls back to 1
    task automatic write_seed(logic [SEED_W-1:0] v);
        wait_quiet();
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        coin_lfsr = (v == '0) ? LFSR_RESET : v;
        n_seeds++;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // edges, stacked grains, a duplicate place, an ignored kind, two advances and reads around them
    task automatic queue_directed();
        req_q.push_back(mk(REQ_PLACE, 0, 63));
        req_q.push_back(mk(REQ_PLACE, 0, 62));
        req_q.push_back(mk(REQ_PLACE, 63, 63));
        req_q.push_back(mk(REQ_PLACE, 63, 62));
        req_q.push_back(mk(REQ_PLACE, 63, 0));
        req_q.push_back(mk(REQ_PLACE, 0, 0));
        req_q.push_back(mk(REQ_PLACE, 31, 63));
        req_q.push_back(mk(REQ_PLACE, 31, 62));
        req_q.push_back(mk(REQ_PLACE, 31, 61));
        req_q.push_back(mk(REQ_PLACE, 31, 61));
        req_q.push_back(mk(REQ_BOGUS, 63, 63));
        req_q.push_back(mk(REQ_READ, 0, 0));
        req_q.push_back(mk(REQ_READ, 63, 63));
        req_q.push_back(mk(REQ_READ, 31, 0));
        req_q.push_back(mk(REQ_ADVANCE, 63, 63));
        req_q.push_back(mk(REQ_READ, 0, 0));
        req_q.push_back(mk(REQ_READ, 1, 0));
        req_q.push_back(mk(REQ_READ, 30, 0));
        req_q.push_back(mk(REQ_READ, 32, 0));
        req_q.push_back(mk(REQ_READ, 62, 0));
        req_q.push_back(mk(REQ_ADVANCE, 0, 0));
        req_q.push_back(mk(REQ_READ, 63, 0));
        req_q.push_back(mk(REQ_READ, 10, 0));
    endtask

    // random segments: piles, generation bursts, column sweeps, scattered grains, noise, place-read-advance-read probes
    task automatic queue_random(int n);
        int made;
        int pick;
        int base;
        int len;
        int row;
        made = 0;
        while (made < n) begin
            pick = $urandom_range(99);
            base = ($urandom_range(9) == 0) ? ($urandom_range(1) ? GRID_COLS - 1 : 0)
                                            : $urandom_range(GRID_COLS - 1);
            len  = $urandom_range(12, 3);
            if (pick < 40) begin
                // pile of grains around one column, mostly near the top or bottom
                for (int k = 0; k < len; k++) begin
                    case ($urandom_range(2))
                        0:       row = $urandom_range(7);
                        1:       row = $urandom_range(GRID_ROWS - 1, GRID_ROWS - 8);
                        default: row = $urandom_range(GRID_ROWS - 1);
                    endcase
                    req_q.push_back(mk(REQ_PLACE, clamp_col(base + $urandom_range(4) - 2), row));
                end
                made += len;
            end else if (pick < 55) begin
                len = $urandom_range(3, 1);
                for (int k = 0; k < len; k++) begin
                    req_q.push_back(mk(REQ_ADVANCE, $urandom_range(63), $urandom_range(63)));
                end
                made += len;
            end else if (pick < 85) begin
                len = $urandom_range(8, 3);
                for (int k = 0; k < len; k++) begin
                    req_q.push_back(mk(REQ_READ, (base + k) % GRID_COLS, $urandom_range(63)));
                end
                made += len;
            end else if (pick < 92) begin
                len = $urandom_range(4, 1);
                for (int k = 0; k < len; k++) begin
                    req_q.push_back(mk(REQ_PLACE, $urandom_range(63), $urandom_range(63)));
                end
                made += len;
            end else if (pick < 96) begin
                req_q.push_back(mk(REQ_BOGUS, $urandom_range(63), $urandom_range(63)));
            end else begin
                row = $urandom_range(63);
                req_q.push_back(mk(REQ_PLACE, base, row));
                req_q.push_back(mk(REQ_READ, base, $urandom_range(63)));
                req_q.push_back(mk(REQ_ADVANCE, $urandom_range(63), $urandom_range(63)));
                req_q.push_back(mk(REQ_READ, base, $urandom_range(63)));
                made += 4;
            end
        end
    endtask

    // test sequence
    initial begin
        for (int c = 0; c < GRID_COLS; c++) begin
            pile[c] = '0;
        end
        coin_lfsr = LFSR_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        write_seed('0);
        queue_directed();

        write_seed('1);
        queue_random(380);

        write_seed($urandom());
        idle_pct = 0;
        queue_random(380);

        write_seed(32'h8000_0000);
        idle_pct = 16;
        queue_random(350);

        write_seed(LFSR_RESET);
        queue_random(330);
        wait_quiet();

        $display("covered %0d places, %0d generations, %0d column reads, %0d ignored beats",
                 n_place, n_adv, n_read, n_drop);
        $display("%0d seeds loaded incl. zero and all-ones, one %0d-cycle output hold, %0d errors",
                 n_seeds, HOLD_CYC, n_err);
        if (n_err == 0) begin
            $display("PASS falling_sand_grid_step");
        end else begin
            $display("FAIL falling_sand_grid_step");
        end
        $finish;
    end

endmodule
